@@ src/crb_pkg.sv @@
// Shared types, codes and key matching for the coalescing backlog ring.
package crb_pkg;

	localparam int ADDR_W    = 64;
	localparam int PAY_W     = 64;
	localparam int TIME_W    = 63;
	localparam int RKEY_W    = 48;

	localparam logic [1:0] OP_PUSH = 2'd0;
	localparam logic [1:0] OP_COAL = 2'd1;
	localparam logic [1:0] OP_POP  = 2'd2;

	localparam logic [2:0] TAG_READING  = 3'd0;
	localparam logic [2:0] TAG_MEAS     = 3'd1;
	localparam logic [2:0] TAG_STATUS   = 3'd2;
	localparam logic [2:0] TAG_ANNOUNCE = 3'd3;
	localparam logic [2:0] TAG_GONE     = 3'd4;

	typedef struct packed {
		logic [7:0] cap;
		logic [7:0] kind;
		logic [2:0] tag;
	} meta_t;

	localparam int META_W = $bits(meta_t);
	localparam int KEY_W  = META_W + ADDR_W;
	localparam int DATA_W = PAY_W + TIME_W;

	function automatic logic keys_match(meta_t sm, logic [ADDR_W-1:0] sa,
			meta_t nm, logic [ADDR_W-1:0] na);
		logic dev_s;
		logic dev_n;
		logic r;
		dev_s = (sm.tag == TAG_ANNOUNCE) || (sm.tag == TAG_GONE);
		dev_n = (nm.tag == TAG_ANNOUNCE) || (nm.tag == TAG_GONE);
		r = 1'b0;
		if (sm.tag == TAG_READING && nm.tag == TAG_READING) begin
			r = (sa[RKEY_W-1:0] == na[RKEY_W-1:0]);
		end else if (sm.tag == TAG_MEAS && nm.tag == TAG_MEAS) begin
			r = (sm.kind == nm.kind) && (sa == na) && (sm.cap == nm.cap);
		end else if (sm.tag == TAG_STATUS && nm.tag == TAG_STATUS) begin
			r = 1'b1;
		end else if (dev_s && dev_n) begin
			// announce and gone share one key space
			r = (sm.kind == nm.kind) && (sa == na);
		end
		return r;
	endfunction

endpackage

@@ src/coalescing_ring_backlog_top.sv @@
// Top level of the coalescing backlog ring: sequencer, pointers and slot memories.
//
//  channel | handshake             | payload
//  --------+-----------------------+--------------------------------------------------
//  in      | in_valid / in_ready   | op tag dev_kind address cap_id payload now_us
//  out     | out_valid / out_ready | coalesced pop_valid out_tag out_kind out_address
//          |                       | out_cap_id out_payload out_captured_us
//          |                       | held_count drop_total
//
// One item at a time. Plain push: dispatch, then write. Empty pop or unused op: dispatch
// only. Pop of a record: dispatch, then pop (one slot-memory read). Coalescing push:
// dispatch, N records compared one per cycle off the key memory read port, then write.
// Reset clears pointers, fill level and drop counter; slot memories are not cleared.
// A result waiting in the output register stalls the sequencer in its final state.
module coalescing_ring_backlog_top #(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [2:0]  tag,
	input  logic [7:0]  dev_kind,
	input  logic [63:0] address,
	input  logic [7:0]  cap_id,
	input  logic [63:0] payload,
	input  logic [62:0] now_us,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        coalesced,
	output logic        pop_valid,
	output logic [2:0]  out_tag,
	output logic [7:0]  out_kind,
	output logic [63:0] out_address,
	output logic [7:0]  out_cap_id,
	output logic [63:0] out_payload,
	output logic [62:0] out_captured_us,
	output logic [4:0]  held_count,
	output logic [31:0] drop_total
);
	import crb_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_DISPATCH = 3'd1;
	localparam logic [2:0] ST_SCAN     = 3'd2;
	localparam logic [2:0] ST_WRITE    = 3'd3;
	localparam logic [2:0] ST_POP      = 3'd4;

	logic [2:0]        state_q, state_d;
	logic [AW-1:0]     oldest_q, oldest_d;
	logic [CW-1:0]     fill_q, fill_d;
	logic [31:0]       drop_q, drop_d;
	logic [AW-1:0]     scan_idx_q, scan_idx_d;
	logic [CW-1:0]     scan_left_q, scan_left_d;
	logic [AW-1:0]     tgt_q, tgt_d;
	logic              hit_q, hit_d;

	logic [1:0]        op_q;
	meta_t             meta_q;
	logic [ADDR_W-1:0] addr_q;
	logic [PAY_W-1:0]  pay_q;
	logic [TIME_W-1:0] now_q;

	logic              out_valid_q;
	logic              coal_q;
	logic              popv_q;
	meta_t             res_meta_q;
	logic [ADDR_W-1:0] res_addr_q;
	logic [PAY_W-1:0]  res_pay_q;
	logic [TIME_W-1:0] res_time_q;
	logic [4:0]        held_q;
	logic [31:0]       drop_out_q;

	logic              key_re, data_re, mem_we;
	logic [AW-1:0]     rd_addr, wr_addr;
	logic [KEY_W-1:0]  key_rd;
	logic [DATA_W-1:0] data_rd;

	logic              res_load, res_coal, res_pop;
	meta_t             res_meta;
	logic [ADDR_W-1:0] res_addr;
	logic [PAY_W-1:0]  res_pay;
	logic [TIME_W-1:0] res_time;

	logic              full, out_free;
	logic [SW-1:0]     push_sum;
	logic [AW-1:0]     push_idx, oldest_inc, scan_inc;
	meta_t             st_meta;
	logic [ADDR_W-1:0] st_addr;

	crb_mem #(.WIDTH(KEY_W), .DEPTH(DEPTH)) u_key_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (wr_addr),
		.wdata ({meta_q, addr_q}),
		.re    (key_re),
		.raddr (rd_addr),
		.rdata (key_rd)
	);

	crb_mem #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_data_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (wr_addr),
		.wdata ({pay_q, now_q}),
		.re    (data_re),
		.raddr (rd_addr),
		.rdata (data_rd)
	);

	assign st_meta  = key_rd[KEY_W-1:ADDR_W];
	assign st_addr  = key_rd[ADDR_W-1:0];
	assign full     = (fill_q == CW'(DEPTH));
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);

	assign push_sum   = SW'(oldest_q) + SW'(fill_q);
	assign push_idx   = (push_sum >= SW'(DEPTH)) ? AW'(push_sum - SW'(DEPTH)) : AW'(push_sum);
	assign oldest_inc = (oldest_q == AW'(DEPTH - 1)) ? '0 : oldest_q + 1'b1;
	assign scan_inc   = (scan_idx_q == AW'(DEPTH - 1)) ? '0 : scan_idx_q + 1'b1;

	always_comb begin
		state_d     = state_q;
		oldest_d    = oldest_q;
		fill_d      = fill_q;
		drop_d      = drop_q;
		scan_idx_d  = scan_idx_q;
		scan_left_d = scan_left_q;
		tgt_d       = tgt_q;
		hit_d       = hit_q;
		key_re      = 1'b0;
		data_re     = 1'b0;
		rd_addr     = oldest_q;
		mem_we      = 1'b0;
		wr_addr     = push_idx;
		res_load    = 1'b0;
		res_coal    = 1'b0;
		res_pop     = 1'b0;
		res_meta    = '0;
		res_addr    = '0;
		res_pay     = '0;
		res_time    = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				case (op_q)
					OP_PUSH: begin
						hit_d   = 1'b0;
						state_d = ST_WRITE;
					end
					OP_COAL: begin
						hit_d = 1'b0;
						if (fill_q == '0) begin
							state_d = ST_WRITE;
						end else begin
							key_re      = 1'b1;
							scan_idx_d  = oldest_q;
							scan_left_d = fill_q;
							state_d     = ST_SCAN;
						end
					end
					OP_POP: begin
						if (fill_q != '0) begin
							key_re  = 1'b1;
							data_re = 1'b1;
							state_d = ST_POP;
						end else if (out_free) begin
							res_load = 1'b1;
							state_d  = ST_IDLE;
						end
					end
					default: begin
						if (out_free) begin
							res_load = 1'b1;
							state_d  = ST_IDLE;
						end
					end
				endcase
			end
			ST_SCAN: begin
				// key_rd holds the record at scan_idx_q; fetch the next one meanwhile
				if (keys_match(st_meta, st_addr, meta_q, addr_q)) begin
					hit_d   = 1'b1;
					tgt_d   = scan_idx_q;
					state_d = ST_WRITE;
				end else if (scan_left_q == CW'(1)) begin
					state_d = ST_WRITE;
				end else begin
					scan_idx_d  = scan_inc;
					scan_left_d = scan_left_q - 1'b1;
					key_re      = 1'b1;
					rd_addr     = scan_inc;
				end
			end
			ST_WRITE: begin
				if (out_free) begin
					mem_we   = 1'b1;
					res_load = 1'b1;
					state_d  = ST_IDLE;
					if (hit_q) begin
						wr_addr  = tgt_q;
						res_coal = 1'b1;
					end else if (full) begin
						// overwrite the oldest record and count the drop
						wr_addr  = oldest_q;
						oldest_d = oldest_inc;
						drop_d   = drop_q + 1'b1;
					end else begin
						fill_d = fill_q + 1'b1;
					end
				end
			end
			ST_POP: begin
				if (out_free) begin
					res_load = 1'b1;
					res_pop  = 1'b1;
					res_meta = st_meta;
					res_addr = st_addr;
					res_pay  = data_rd[DATA_W-1:TIME_W];
					res_time = data_rd[TIME_W-1:0];
					oldest_d = oldest_inc;
					fill_d   = fill_q - 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			oldest_q    <= '0;
			fill_q      <= '0;
			drop_q      <= '0;
			scan_idx_q  <= '0;
			scan_left_q <= '0;
			tgt_q       <= '0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			oldest_q    <= oldest_d;
			fill_q      <= fill_d;
			drop_q      <= drop_d;
			scan_idx_q  <= scan_idx_d;
			scan_left_q <= scan_left_d;
			tgt_q       <= tgt_d;
			hit_q       <= hit_d;
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// capture the item on transfer
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q        <= op;
			meta_q.tag  <= tag;
			meta_q.kind <= dev_kind;
			meta_q.cap  <= cap_id;
			addr_q      <= address;
			pay_q       <= payload;
			now_q       <= now_us;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			coal_q     <= res_coal;
			popv_q     <= res_pop;
			res_meta_q <= res_meta;
			res_addr_q <= res_addr;
			res_pay_q  <= res_pay;
			res_time_q <= res_time;
			held_q     <= 5'(fill_d);
			drop_out_q <= drop_d;
		end
	end

	assign out_valid       = out_valid_q;
	assign coalesced       = coal_q;
	assign pop_valid       = popv_q;
	assign out_tag         = res_meta_q.tag;
	assign out_kind        = res_meta_q.kind;
	assign out_address     = res_addr_q;
	assign out_cap_id      = res_meta_q.cap;
	assign out_payload     = res_pay_q;
	assign out_captured_us = res_time_q;
	assign held_count      = held_q;
	assign drop_total      = drop_out_q;

endmodule

@@ src/crb_mem.sv @@
// Single-port-write, registered-read synchronous RAM for the ring slots.
module crb_mem #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// hold the last read word until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ src/crb_checker.sv @@
// Port-level assertions for the coalescing backlog ring, bound to the top level.
module crb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        coalesced,
	input logic        pop_valid,
	input logic [2:0]  out_tag,
	input logic [7:0]  out_kind,
	input logic [63:0] out_address,
	input logic [7:0]  out_cap_id,
	input logic [63:0] out_payload,
	input logic [62:0] out_captured_us,
	input logic [4:0]  held_count,
	input logic [31:0] drop_total
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(held_count) &&
		$stable(drop_total) && $stable(out_address) && $stable(pop_valid))
		else $error("stalled result changed");

	// one item in flight: ready drops right after a transfer
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready stayed high after an input transfer");

	a_pop_not_coal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(pop_valid && coalesced))
		else $error("result both popped and coalesced");

	// only a pop carries record fields
	a_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !pop_valid |-> out_tag == 3'd0 && out_kind == 8'd0 &&
		out_cap_id == 8'd0 && out_address == 64'd0 && out_payload == 64'd0 &&
		out_captured_us == 63'd0)
		else $error("record fields set without a pop");

endmodule

bind coalescing_ring_backlog_top crb_checker u_crb_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_ready        (in_ready),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.coalesced       (coalesced),
	.pop_valid       (pop_valid),
	.out_tag         (out_tag),
	.out_kind        (out_kind),
	.out_address     (out_address),
	.out_cap_id      (out_cap_id),
	.out_payload     (out_payload),
	.out_captured_us (out_captured_us),
	.held_count      (held_count),
	.drop_total      (drop_total)
);
